// ===== hw/rtl/rld_pkg.sv =====
package rld_pkg;

  // percent scale
  localparam int unsigned PctW   = 7;
  localparam int unsigned StepW  = 6;
  localparam int unsigned DbW    = 4;
  localparam int unsigned TopW   = 16;
  localparam int unsigned Top1W  = TopW + 1;
  localparam int unsigned LevelW = 17;
  localparam int unsigned ProdW  = 23;  // (65535 + 1) * 100 fits in 23 bits

  localparam logic [PctW-1:0] MaxPct = PctW'(100);

  // divide by 100 as multiply by ceil(2^30 / 100) and shift; exact for ProdW-bit values
  localparam int unsigned      RecipShift = 30;
  localparam int unsigned      RecipW     = 24;
  localparam logic [RecipW-1:0] Recip100  = RecipW'(10737419);
  localparam int unsigned      QuotW      = ProdW + RecipW;

  // register reset values
  localparam logic [StepW-1:0] StepPctRst    = StepW'(5);
  localparam logic [PctW-1:0]  DefaultPctRst = PctW'(50);
  localparam logic [DbW-1:0]   DebounceRst   = DbW'(3);
  localparam logic [TopW-1:0]  PwmTopRst     = TopW'(999);

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CfgStepPct    = 2'd0,
    CfgDefaultPct = 2'd1,
    CfgDebounce   = 2'd2,
    CfgPwmTop     = 2'd3
  } cfg_idx_e;

endpackage

// ===== hw/rtl/rotary_led_dimmer_control_core.sv =====
// rotary encoder led dimmer: each input beat is one sample of encoder phases a and b and the
// active-low push switch. a rising edge on a while the lights are on steps the brightness up
// (b low) or down (b high) by step_pct, saturating at 0 and 100 percent. the switch is
// debounced over debounce_samples differing samples in a row; each accepted press toggles the
// lights, an accepted release re-arms the toggle. switching off saves the brightness, switching
// on restores it or uses default_on_pct when the saved value is 0. every input beat yields one
// output beat with the on state, the brightness and the pwm compare level
// (pwm_top+1)*pct/100. one beat is accepted per clock unless the output stalls; results pass
// the state register and the two multiplier stages (scale by pwm_top+1, then divide by 100 as
// a reciprocal multiply). configuration writes are taken at any time but are meant for idle.
module rotary_led_dimmer_control_core
  import rld_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // input samples
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [0] enc_a, [1] enc_b, [2] switch_level
  // results
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [31:0]         m_axis_tdata    // [0] lights_on, [7:1] brightness_pct,
                                              // [24:8] compare_level
);

  // configuration registers
  logic [StepW-1:0] step_q;
  logic [PctW-1:0]  default_q;
  logic [DbW-1:0]   debounce_q;
  logic [TopW-1:0]  top_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q     <= StepPctRst;
      default_q  <= DefaultPctRst;
      debounce_q <= DebounceRst;
      top_q      <= PwmTopRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgStepPct:    step_q     <= cfg_data_i[StepW-1:0];
        CfgDefaultPct: default_q  <= cfg_data_i[PctW-1:0];
        CfgDebounce:   debounce_q <= cfg_data_i[DbW-1:0];
        CfgPwmTop:     top_q      <= cfg_data_i[TopW-1:0];
        default:       ;
      endcase
    end
  end

  // pipeline valids and stall chain: each stage moves when the one after it can take it
  logic v0_q, v1_q, v2_q;
  logic en0, en1, en2;

  assign en2 = !v2_q || m_axis_tready;
  assign en1 = !v1_q || en2;
  assign en0 = !v0_q || en1;

  assign s_axis_tready = en0;

  logic in_acc;
  assign in_acc = s_axis_tvalid && en0;

  // input sample fields
  logic enc_a, enc_b, sw_lvl;
  assign enc_a  = s_axis_tdata[0];
  assign enc_b  = s_axis_tdata[1];
  assign sw_lvl = s_axis_tdata[2];

  // dimmer state
  logic           prev_a_q, prev_a_d;
  logic [DbW-1:0] run_cnt_q, run_cnt_d;
  logic           stable_q, stable_d;
  logic           armed_q, armed_d;
  logic           on_q, on_d;
  logic [PctW-1:0] duty_q, duty_d;
  logic [PctW-1:0] saved_q, saved_d;

  logic            detent;
  logic [PctW:0]   duty_sum;
  logic [PctW-1:0] duty_rot;
  logic [DbW-1:0]  need;
  logic [DbW-1:0]  run_inc;
  logic [PctW-1:0] restore_pct;
  logic [PctW-1:0] default_sat;

  always_comb begin
    prev_a_d  = enc_a;
    run_cnt_d = run_cnt_q;
    stable_d  = stable_q;
    armed_d   = armed_q;
    on_d      = on_q;
    saved_d   = saved_q;

    // rotation first, only while lit
    detent   = enc_a && !prev_a_q && on_q;
    duty_sum = {1'b0, duty_q} + {2'b00, step_q};
    duty_rot = duty_q;
    if (detent) begin
      if (!enc_b) begin
        duty_rot = (duty_sum > {1'b0, MaxPct}) ? MaxPct : duty_sum[PctW-1:0];
      end else begin
        duty_rot = (duty_q > {1'b0, step_q}) ? (duty_q - {1'b0, step_q}) : '0;
      end
    end
    duty_d = duty_rot;

    default_sat = (default_q > MaxPct) ? MaxPct : default_q;
    restore_pct = (saved_q == '0) ? default_sat : saved_q;

    // debounce: zero sample count acts as one
    need    = (debounce_q == '0) ? DbW'(1) : debounce_q;
    run_inc = run_cnt_q + DbW'(1);

    if (sw_lvl == stable_q) begin
      run_cnt_d = '0;
    end else if (run_inc >= need) begin
      run_cnt_d = '0;
      stable_d  = sw_lvl;
      if (!sw_lvl) begin
        if (armed_q) begin
          armed_d = 1'b0;
          if (on_q) begin
            saved_d = duty_rot;
            duty_d  = '0;
            on_d    = 1'b0;
          end else begin
            duty_d = restore_pct;
            on_d   = 1'b1;
          end
        end
      end else begin
        armed_d = 1'b1;
      end
    end else begin
      run_cnt_d = run_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_a_q  <= 1'b0;
      run_cnt_q <= '0;
      stable_q  <= 1'b1;
      armed_q   <= 1'b1;
      on_q      <= 1'b0;
      duty_q    <= '0;
      saved_q   <= '0;
    end else if (in_acc) begin
      prev_a_q  <= prev_a_d;
      run_cnt_q <= run_cnt_d;
      stable_q  <= stable_d;
      armed_q   <= armed_d;
      on_q      <= on_d;
      duty_q    <= duty_d;
      saved_q   <= saved_d;
    end
  end

  // stage 0: state after this sample, plus the pwm span
  logic             on0_q;
  logic [PctW-1:0]  duty0_q;
  logic [Top1W-1:0] top1_q;

  // stage 1: scaled product
  logic             on1_q;
  logic [PctW-1:0]  duty1_q;
  logic [ProdW-1:0] prod_q, prod_d;

  // stage 2: output register
  logic              on2_q;
  logic [PctW-1:0]   duty2_q;
  logic [LevelW-1:0] level_q, level_d;
  logic [QuotW-1:0]  quot;

  // both operands at full product width so the top of the product is kept
  assign prod_d  = {{(ProdW-Top1W){1'b0}}, top1_q} * {{(ProdW-PctW){1'b0}}, duty0_q};
  assign quot    = {{RecipW{1'b0}}, prod_q} * {{ProdW{1'b0}}, Recip100};
  assign level_d = quot[RecipShift +: LevelW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en0) v0_q <= s_axis_tvalid;
      if (en1) v1_q <= v0_q;
      if (en2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      on0_q   <= on_d;
      duty0_q <= duty_d;
      top1_q  <= {1'b0, top_q} + Top1W'(1);
    end
    if (en1 && v0_q) begin
      on1_q   <= on0_q;
      duty1_q <= duty0_q;
      prod_q  <= prod_d;
    end
    if (en2 && v1_q) begin
      on2_q   <= on1_q;
      duty2_q <= duty1_q;
      level_q <= level_d;
    end
  end

  assign m_axis_tvalid = v2_q;
  assign m_axis_tdata  = {7'b0, level_q, duty2_q, on2_q};

endmodule

// ===== tb/tb_rotary_led_dimmer_control_core.sv =====
`timescale 1ns / 100ps

module tb_rotary_led_dimmer_control_core;
  import rld_pkg::*;

  // one result beat as the block packs it
  typedef struct packed {
    logic              lit;
    logic [PctW-1:0]   pct;
    logic [LevelW-1:0] level;
  } dimmer_out_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // configuration channel, driven only by the stimulus block
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  cfg_idx_e            cfg_index_i = CfgStepPct;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;  // [0] enc_a, [1] enc_b, [2] switch_level
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [0] lights_on, [7:1] brightness_pct, [24:8] compare_level

  // pin samples waiting for the driver, packed {switch_level, enc_b, enc_a}
  logic [2:0]  sample_q [$];
  // predicted result beats, oldest first
  dimmer_out_t expected_out_q [$];

  // handshakes seen at the last rising edge, used by the driver at the falling edge
  logic in_taken  = 1'b0;
  logic out_taken = 1'b0;

  int unsigned send_idle_pct  = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned err_cnt        = 0;

  // predictor copy of the registers
  logic [StepW-1:0] m_step = StepPctRst;
  logic [PctW-1:0]  m_def  = DefaultPctRst;
  logic [DbW-1:0]   m_db   = DebounceRst;
  logic [TopW-1:0]  m_top  = PwmTopRst;

  // predictor copy of the dimmer state
  logic             m_prev_a = 1'b0;
  logic [DbW-1:0]   m_run    = '0;
  logic             m_stable = 1'b1;  // released
  logic             m_armed  = 1'b1;
  logic             m_lit    = 1'b0;
  logic [PctW-1:0]  m_duty   = '0;
  logic [PctW-1:0]  m_saved  = '0;

  // sample generator state: quadrature position, turning direction, switch hold
  logic [1:0]  quad    = 2'd0;
  logic        turn_dn = 1'b0;
  logic        sw_lvl  = 1'b1;
  int unsigned sw_left = 0;
  int unsigned db_need = 3;

  always #10 clk_i = ~clk_i;

  rotary_led_dimmer_control_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // advance the dimmer by one pin sample and give the result beat it produces
  task automatic predict_dimmer_out(input logic [2:0] pins, output dimmer_out_t res);
    logic        a;
    logic        b;
    logic        sw;
    int unsigned up_pct;
    int unsigned need;
    int unsigned lvl;
    a  = pins[0];
    b  = pins[1];
    sw = pins[2];

    // rotation first, only a rising edge on a while lit
    if (a && !m_prev_a && m_lit) begin
      if (!b) begin
        up_pct = m_duty + m_step;
        m_duty = (up_pct > 100) ? MaxPct : PctW'(up_pct);
      end else begin
        m_duty = (m_duty > m_step) ? PctW'(m_duty - m_step) : '0;
      end
    end
    m_prev_a = a;

    // debounce: a run of differing samples moves the stable level
    need = (m_db == 0) ? 1 : m_db;
    if (sw == m_stable) begin
      m_run = '0;
    end else begin
      m_run = m_run + 1'b1;
      if (m_run >= need) begin
        m_stable = sw;
        m_run    = '0;
        if (!sw) begin
          if (m_armed) begin
            // press toggles once per arm
            if (m_lit) begin
              m_saved = m_duty;
              m_duty  = '0;
              m_lit   = 1'b0;
            end else begin
              if (m_saved != 0) m_duty = m_saved;
              else m_duty = (m_def > MaxPct) ? MaxPct : m_def;
              m_lit = 1'b1;
            end
            m_armed = 1'b0;
          end
        end else begin
          m_armed = 1'b1;
        end
      end
    end

    lvl       = (32'(m_top) + 32'd1) * 32'(m_duty) / 32'd100;
    res.lit   = m_lit;
    res.pct   = m_duty;
    res.level = lvl[LevelW-1:0];
  endtask

  // input driver: next sample goes out once the current one is taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || in_taken) begin
        if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tdata  <= {5'b0, sample_q.pop_front()};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // monitor: register writes, accepted samples and result beats, all at the rising edge
  always @(posedge clk_i) begin
    dimmer_out_t exp_out;
    dimmer_out_t new_out;
    in_taken  = s_axis_tvalid && s_axis_tready;
    out_taken = m_axis_tvalid && m_axis_tready;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgStepPct:    m_step = cfg_data_i[StepW-1:0];
          CfgDefaultPct: m_def  = cfg_data_i[PctW-1:0];
          CfgDebounce:   m_db   = cfg_data_i[DbW-1:0];
          CfgPwmTop:     m_top  = cfg_data_i[TopW-1:0];
          default: ;
        endcase
      end

      if (out_taken) begin
        if (expected_out_q.size() == 0) begin
          if (err_cnt < 10) $display("result beat with nothing expected: %h", m_axis_tdata);
          err_cnt++;
        end else begin
          exp_out = expected_out_q.pop_front();
          if (m_axis_tdata[0] !== exp_out.lit || m_axis_tdata[7:1] !== exp_out.pct ||
              m_axis_tdata[24:8] !== exp_out.level) begin
            if (err_cnt < 10)
              $display("mismatch: exp on=%0d pct=%0d lvl=%0d, got on=%0d pct=%0d lvl=%0d",
                       exp_out.lit, exp_out.pct, exp_out.level,
                       m_axis_tdata[0], m_axis_tdata[7:1], m_axis_tdata[24:8]);
            err_cnt++;
          end
        end
      end

      if (in_taken) begin
        predict_dimmer_out(s_axis_tdata[2:0], new_out);
        expected_out_q.push_back(new_out);
      end
    end
  end

  // wait until every sample is out and every result is back, then let the pipe settle
  task automatic wait_drained();
    @(posedge clk_i);
    while (sample_q.size() != 0 || s_axis_tvalid || expected_out_q.size() != 0)
      @(posedge clk_i);
    repeat (5) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // drain, reprogram all registers and pick the idling mix for the next stretch
  task automatic set_phase(input int unsigned step, input int unsigned def_pct,
                           input int unsigned db, input int unsigned top,
                           input int unsigned send_idle, input int unsigned sink_stall);
    wait_drained();
    write_reg(CfgStepPct, CfgDataW'(step));
    write_reg(CfgDefaultPct, CfgDataW'(def_pct));
    write_reg(CfgDebounce, CfgDataW'(db));
    write_reg(CfgPwmTop, CfgDataW'(top));
    db_need        = (db == 0) ? 1 : db;
    send_idle_pct  = send_idle;
    sink_stall_pct = sink_stall;
  endtask

  // mostly real encoder turns and held presses, with bounces and random pins mixed in
  task automatic queue_samples(input int unsigned n_items);
    logic [2:0] pins;
    for (int unsigned k = 0; k < n_items; k++) begin
      if (sw_left == 0) begin
        sw_lvl = ~sw_lvl;
        if ($urandom_range(9) == 0) sw_left = $urandom_range(1, 3);  // contact bounce
        else sw_left = db_need + $urandom_range(0, 12);
      end
      sw_left--;
      if ($urandom_range(19) == 0) turn_dn = ~turn_dn;
      if ($urandom_range(2) != 0) quad = turn_dn ? quad - 2'd1 : quad + 2'd1;
      // gray coding: a rises with b low turning up, with b high turning down
      pins = {sw_lvl, quad[1], quad[1] ^ quad[0]};
      if ($urandom_range(19) == 0) pins = 3'($urandom_range(7));
      sample_q.push_back(pins);
    end
  endtask

  initial begin : stim
    // directed beats {switch_level, enc_b, enc_a}
    logic [2:0]  clamp_seq [10] = '{
      3'b101,  // a rises while dark: ignored
      3'b000,  // press with zero debounce count, nothing saved: on at clamped default
      3'b001,  // step up past the top: saturates at 100
      3'b110,  // release re-arms
      3'b111,  // step down
      3'b110,
      3'b111,  // step down lands exactly on zero
      3'b010,  // press: off at zero, saves zero
      3'b100,
      3'b000   // press: saved zero falls back to the default
    };
    logic [2:0]  zero_seq [9] = '{
      3'b111,  // big step down from full, release
      3'b110,
      3'b111,  // step down past zero: saturates
      3'b000,  // off at zero
      3'b100,
      3'b000,  // on with default zero: lit at 0 percent
      3'b001,  // step up from zero
      3'b000,
      3'b001   // step up past the top with top of zero in the level
    };
    int unsigned step_tab [5] = '{5, 0, 1, 50, 63};
    int unsigned def_tab  [5] = '{50, 100, 1, 127, 0};
    int unsigned db_tab   [5] = '{3, 15, 2, 0, 1};
    int unsigned top_tab  [5] = '{999, 65535, 1, 0, 40000};
    int unsigned send_tab [4] = '{0, 51, 0, 32};
    int unsigned sink_tab [4] = '{0, 0, 51, 32};

    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: largest valid step, default above 100, zero debounce, widest top
    set_phase(50, 127, 0, 65535, 0, 0);
    foreach (clamp_seq[i]) sample_q.push_back(clamp_seq[i]);

    // directed: oversize step, default zero, top zero
    set_phase(63, 0, 1, 0, 0, 0);
    foreach (zero_seq[i]) sample_q.push_back(zero_seq[i]);

    // random stretches, fixed corner settings first, then in-range random ones
    for (int unsigned ph = 0; ph < 8; ph++) begin
      if (ph < 5)
        set_phase(step_tab[ph], def_tab[ph], db_tab[ph], top_tab[ph],
                  send_tab[ph % 4], sink_tab[ph % 4]);
      else
        set_phase($urandom_range(1, 50), $urandom_range(1, 100), $urandom_range(1, 15),
                  $urandom_range(1, 65535), send_tab[ph % 4], sink_tab[ph % 4]);
      queue_samples(130);
    end

    wait_drained();
    if (err_cnt == 0) begin
      $display("tb_rotary_led_dimmer_control_core: done, clean");
    end else begin
      $display("tb_rotary_led_dimmer_control_core: done, errors");
    end
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin
    #5_000_000;
    $display("tb_rotary_led_dimmer_control_core: done, errors");
    $finish;
  end

endmodule
